// File: hw/rtl/ieu_pkg.sv
// ----------------------------------------------------------------------------
// ieu_pkg
// Shared operation codes, condition codes and the queued item type of the
// integer execute unit.
// ----------------------------------------------------------------------------
package ieu_pkg;

   localparam int KIND_W  = 5;
   localparam int COND_W  = 3;
   localparam int WORD_W  = 64;
   localparam int HALF_W  = 32;
   localparam int INDEX_W = 16;
   localparam int OP_W    = 3;

   localparam logic [KIND_W-1:0] K_ADD       = 5'd0;
   localparam logic [KIND_W-1:0] K_SUB       = 5'd1;
   localparam logic [KIND_W-1:0] K_AND       = 5'd2;
   localparam logic [KIND_W-1:0] K_OR        = 5'd3;
   localparam logic [KIND_W-1:0] K_XOR       = 5'd4;
   localparam logic [KIND_W-1:0] K_NOT       = 5'd5;
   localparam logic [KIND_W-1:0] K_SLL       = 5'd6;
   localparam logic [KIND_W-1:0] K_SRL       = 5'd7;
   localparam logic [KIND_W-1:0] K_SRA       = 5'd8;
   localparam logic [KIND_W-1:0] K_AND64     = 5'd9;
   localparam logic [KIND_W-1:0] K_MOV32     = 5'd10;
   localparam logic [KIND_W-1:0] K_MOV64     = 5'd11;
   localparam logic [KIND_W-1:0] K_EXTLOW    = 5'd12;
   localparam logic [KIND_W-1:0] K_EXTHIGH   = 5'd13;
   localparam logic [KIND_W-1:0] K_MUL       = 5'd14;
   localparam logic [KIND_W-1:0] K_MULS      = 5'd15;
   localparam logic [KIND_W-1:0] K_DIV       = 5'd16;
   localparam logic [KIND_W-1:0] K_DIVS      = 5'd17;
   localparam logic [KIND_W-1:0] K_CMP       = 5'd18;
   localparam logic [KIND_W-1:0] K_CMP64     = 5'd19;
   localparam logic [KIND_W-1:0] K_CONDJMP   = 5'd20;
   localparam logic [KIND_W-1:0] K_CONDJMP_P = 5'd21;
   localparam logic [KIND_W-1:0] K_JMP       = 5'd22;

   localparam logic [COND_W-1:0] CC_EQ  = 3'd0;
   localparam logic [COND_W-1:0] CC_NE  = 3'd1;
   localparam logic [COND_W-1:0] CC_SLT = 3'd2;
   localparam logic [COND_W-1:0] CC_SGT = 3'd3;
   localparam logic [COND_W-1:0] CC_ULT = 3'd4;

   localparam logic [OP_W-1:0] OP_PASS = 3'd0;
   localparam logic [OP_W-1:0] OP_MULU = 3'd1;
   localparam logic [OP_W-1:0] OP_MULS = 3'd2;
   localparam logic [OP_W-1:0] OP_DIVU = 3'd3;
   localparam logic [OP_W-1:0] OP_DIVS = 3'd4;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [WORD_W-1:0]  res;
      logic               taken;
      logic [INDEX_W-1:0] nxt;
      logic               bad;
      logic [HALF_W-1:0]  a32;
      logic [HALF_W-1:0]  b32;
   } item_type;

endpackage

// File: hw/rtl/ieu_front.sv
// ----------------------------------------------------------------------------
// ieu_front
// Decodes an incoming beat, evaluates the logic, arithmetic, shift and move
// operations, compares and jumps, and tags multiplies and divides for the back end.
// ----------------------------------------------------------------------------
module ieu_front (
   input  logic [ieu_pkg::KIND_W-1:0]  kind,
   input  logic [ieu_pkg::COND_W-1:0]  cond_code,
   input  logic [ieu_pkg::WORD_W-1:0]  src_a,
   input  logic [ieu_pkg::WORD_W-1:0]  src_b,
   input  logic [ieu_pkg::INDEX_W-1:0] cur_index,
   input  logic [ieu_pkg::INDEX_W-1:0] target_index,
   output ieu_pkg::item_type           item
);
   import ieu_pkg::*;

   logic [HALF_W-1:0] a32;
   logic [HALF_W-1:0] b32;
   logic [4:0]        sh;

   assign a32 = src_a[HALF_W-1:0];
   assign b32 = src_b[HALF_W-1:0];
   assign sh  = b32[4:0];

   always_comb begin
      item       = '0;
      item.op    = OP_PASS;
      item.a32   = a32;
      item.b32   = b32;
      case (kind)
         K_ADD:     item.res = {32'd0, a32 + b32};
         K_SUB:     item.res = {32'd0, a32 - b32};
         K_AND:     item.res = {32'd0, a32 & b32};
         K_OR:      item.res = {32'd0, a32 | b32};
         K_XOR:     item.res = {32'd0, a32 ^ b32};
         K_NOT:     item.res = {32'd0, ~a32};
         K_SLL:     item.res = {32'd0, a32 << sh};
         K_SRL:     item.res = {32'd0, a32 >> sh};
         K_SRA:     item.res = {32'd0, $unsigned($signed(a32) >>> sh)};
         K_AND64:   item.res = src_a & src_b;
         K_MOV32:   item.res = {32'd0, a32};
         K_MOV64:   item.res = src_a;
         K_EXTLOW:  item.res = {32'd0, a32};
         K_EXTHIGH: item.res = {32'd0, src_a[WORD_W-1:HALF_W]};
         K_MUL:     item.op = OP_MULU;
         K_MULS:    item.op = OP_MULS;
         K_DIV:     item.op = OP_DIVU;
         K_DIVS:    item.op = OP_DIVS;
         K_CMP: begin
            if (cond_code == CC_NE) begin
               item.res = {63'd0, a32 != b32};
            end else if (cond_code == CC_SLT) begin
               item.res = {63'd0, $signed(a32) < $signed(b32)};
            end else begin
               item.bad = 1'b1;
            end
         end
         K_CMP64: begin
            if (cond_code == CC_NE) begin
               item.res = {63'd0, src_a != src_b};
            end else if (cond_code == CC_ULT) begin
               item.res = {63'd0, src_a < src_b};
            end else if (cond_code == CC_SLT) begin
               item.res = {63'd0, $signed(src_a) < $signed(src_b)};
            end else begin
               item.bad = 1'b1;
            end
         end
         K_CONDJMP: begin
            if (cond_code == CC_EQ) begin
               item.taken = (a32 == b32);
            end else if (cond_code == CC_NE) begin
               item.taken = (a32 != b32);
            end else if (cond_code == CC_SGT) begin
               item.taken = ($signed(a32) > $signed(b32));
            end else begin
               item.bad = 1'b1;
            end
         end
         K_CONDJMP_P: begin
            if (cond_code == CC_EQ) begin
               item.taken = (src_a == src_b);
            end else begin
               item.bad = 1'b1;
            end
         end
         K_JMP:     item.taken = 1'b1;
         default:   item.res = '0;
      endcase
      item.nxt = item.taken ? target_index : cur_index + 16'd1;
   end

endmodule

// File: hw/rtl/ieu_queue.sv
// ----------------------------------------------------------------------------
// ieu_queue
// Small first-in first-out buffer of classified items between the front and
// the back end.
// ----------------------------------------------------------------------------
module ieu_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ieu_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output ieu_pkg::item_type pop_item,
   output logic              empty
);
   import ieu_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type          mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in;
   logic [PTR_W-1:0]  rd_ff, rd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              do_push;
   logic              do_pop;

   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

endmodule

// File: hw/rtl/ieu_back.sv
// ----------------------------------------------------------------------------
// ieu_back
// Stallable execution pipeline: a registered multiplier with sign
// correction and a divider that resolves one quotient bit per stage.
// ----------------------------------------------------------------------------
module ieu_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  ieu_pkg::item_type           in_item,
   output logic                        in_take,
   output logic                        out_valid,
   input  logic                        out_take,
   output logic [ieu_pkg::WORD_W-1:0]  out_result,
   output logic                        out_taken,
   output logic [ieu_pkg::INDEX_W-1:0] out_next,
   output logic                        out_bad
);
   import ieu_pkg::*;

   localparam int STEPS = HALF_W;
   localparam int LAST  = STEPS + 2;

   typedef struct packed {
      item_type          it;
      logic [HALF_W-1:0] r;
      logic [HALF_W-1:0] w;
      logic [HALF_W-1:0] d;
   } stage_type;

   stage_type st_ff [LAST+1];
   stage_type st_in [LAST+1];
   logic      vld_ff [LAST+1];
   logic      en;

   assign en        = !vld_ff[LAST] || out_take;
   assign in_take   = en && in_valid;
   assign out_valid = vld_ff[LAST];
   assign out_result = st_ff[LAST].it.res;
   assign out_taken  = st_ff[LAST].it.taken;
   assign out_next   = st_ff[LAST].it.nxt;
   assign out_bad    = st_ff[LAST].it.bad;

   always_comb begin
      logic [HALF_W:0]   trial;
      logic [HALF_W-1:0] corr;
      logic [HALF_W-1:0] q;
      logic [HALF_W-1:0] rm;
      stage_type         s;

      corr       = '0;
      st_in[0]   = '0;
      st_in[0].it = in_item;

      s = st_ff[0];
      if (s.it.op == OP_MULU || s.it.op == OP_MULS) begin
         s.it.res = {32'd0, s.it.a32} * {32'd0, s.it.b32};
      end
      s.r = '0;
      if (s.it.op == OP_DIVS) begin
         s.w = s.it.a32[HALF_W-1] ? -s.it.a32 : s.it.a32;
         s.d = s.it.b32[HALF_W-1] ? -s.it.b32 : s.it.b32;
      end else begin
         s.w = s.it.a32;
         s.d = s.it.b32;
      end
      st_in[1] = s;

      for (int i = 1; i <= STEPS; i++) begin
         s     = st_ff[i];
         trial = {s.r, s.w[HALF_W-1]} - {1'b0, s.d};
         if (!trial[HALF_W]) begin
            s.r = trial[HALF_W-1:0];
            s.w = {s.w[HALF_W-2:0], 1'b1};
         end else begin
            s.r = {s.r[HALF_W-2:0], s.w[HALF_W-1]};
            s.w = {s.w[HALF_W-2:0], 1'b0};
         end
         if (i == 1 && s.it.op == OP_MULS) begin
            corr = (s.it.a32[HALF_W-1] ? s.it.b32 : '0)
                 + (s.it.b32[HALF_W-1] ? s.it.a32 : '0);
            s.it.res[WORD_W-1:HALF_W] = s.it.res[WORD_W-1:HALF_W] - corr;
         end
         st_in[i+1] = s;
      end

      s  = st_ff[LAST-1];
      q  = s.w;
      rm = s.r;
      if (s.it.op == OP_DIVS) begin
         if (s.it.a32[HALF_W-1] != s.it.b32[HALF_W-1]) begin
            q = -s.w;
         end
         if (s.it.a32[HALF_W-1]) begin
            rm = -s.r;
         end
      end
      if (s.it.op == OP_DIVU || s.it.op == OP_DIVS) begin
         if (s.it.b32 == '0) begin
            s.it.res = {s.it.a32, {HALF_W{1'b1}}};
         end else begin
            s.it.res = {rm, q};
         end
      end
      st_in[LAST] = s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= LAST; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= in_valid;
         for (int i = 1; i <= LAST; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i <= LAST; i++) begin
            st_ff[i] <= st_in[i];
         end
      end
   end

endmodule

// File: hw/rtl/ir_integer_execute_unit_top.sv
// ----------------------------------------------------------------------------
// ir_integer_execute_unit_top
// Integer execute stage: front decode, item queue and execution pipeline.
// ----------------------------------------------------------------------------
// The unit accepts one beat per cycle while not full and returns one result
// beat per cycle in order while results are popped. Every item, whatever its
// kind, passes through the same pipeline: one entry stage, one multiply and
// divide set-up stage, 32 divider stages that each resolve one quotient bit,
// and a final result register. Beats wait in the input queue before the
// entry stage. When a result waits unpopped the whole pipeline holds, and the
// queue between the decode logic and the pipeline keeps taking beats until
// it fills.
module ir_integer_execute_unit_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   output logic                        full,
   input  logic [ieu_pkg::KIND_W-1:0]  req_kind,
   input  logic [ieu_pkg::COND_W-1:0]  req_cond_code,
   input  logic [ieu_pkg::WORD_W-1:0]  req_src_a,
   input  logic [ieu_pkg::WORD_W-1:0]  req_src_b,
   input  logic [ieu_pkg::INDEX_W-1:0] req_cur_index,
   input  logic [ieu_pkg::INDEX_W-1:0] req_target_index,
   output logic                        empty,
   input  logic                        pop,
   output logic [ieu_pkg::WORD_W-1:0]  rsp_result,
   output logic                        rsp_taken,
   output logic [ieu_pkg::INDEX_W-1:0] rsp_next_index,
   output logic                        rsp_bad_condition
);
   import ieu_pkg::*;

   item_type front_item;
   item_type queue_item;
   logic     queue_empty;
   logic     back_take;
   logic     back_valid;

   ieu_front u_front (
      .kind         (req_kind),
      .cond_code    (req_cond_code),
      .src_a        (req_src_a),
      .src_b        (req_src_b),
      .cur_index    (req_cur_index),
      .target_index (req_target_index),
      .item         (front_item)
   );

   ieu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .full      (full),
      .pop       (back_take),
      .pop_item  (queue_item),
      .empty     (queue_empty)
   );

   ieu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (!queue_empty),
      .in_item    (queue_item),
      .in_take    (back_take),
      .out_valid  (back_valid),
      .out_take   (pop),
      .out_result (rsp_result),
      .out_taken  (rsp_taken),
      .out_next   (rsp_next_index),
      .out_bad    (rsp_bad_condition)
   );

   assign empty = !back_valid;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_result)))
      else $error("result beat lost while stalled");

   a_jump_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_taken) |-> (rsp_result == '0 && !rsp_bad_condition))
      else $error("taken jump with non-zero result or error");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> empty)
      else $error("result present right after reset");

endmodule

// File: verif/ir_integer_execute_unit_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_integer_execute_unit_top_tb
// Drives decoded instructions into the integer execute unit and checks every
// result beat, in order, against a predictor of the execute stage.
// ----------------------------------------------------------------------------
module ir_integer_execute_unit_top_tb;
   import ieu_pkg::*;

   typedef struct {
      logic [WORD_W-1:0]  result;
      logic               taken;
      logic [INDEX_W-1:0] next_index;
      logic               bad;
   } outcome_type;

   function automatic logic [63:0] pack_quot_rem(logic [31:0] q, logic [31:0] r);
      return {r, q};
   endfunction

   function automatic outcome_type execute_instr(logic [4:0] kind, logic [2:0] cc,
         logic [63:0] a, logic [63:0] b, logic [15:0] cur, logic [15:0] tgt);
      outcome_type o;
      logic [31:0] a32, b32, ma, mb, q, r;
      logic [4:0] sh;
      a32 = a[31:0];
      b32 = b[31:0];
      sh = b32[4:0];
      o.result = '0;
      o.taken = 1'b0;
      o.bad = 1'b0;
      case (kind)
         K_ADD: o.result = {32'd0, a32 + b32};
         K_SUB: o.result = {32'd0, a32 - b32};
         K_AND: o.result = {32'd0, a32 & b32};
         K_OR: o.result = {32'd0, a32 | b32};
         K_XOR: o.result = {32'd0, a32 ^ b32};
         K_NOT: o.result = {32'd0, ~a32};
         K_SLL: o.result = {32'd0, a32 << sh};
         K_SRL: o.result = {32'd0, a32 >> sh};
         K_SRA: o.result = {32'd0, $unsigned($signed(a32) >>> sh)};
         K_AND64: o.result = a & b;
         K_MOV32, K_EXTLOW: o.result = {32'd0, a32};
         K_MOV64: o.result = a;
         K_EXTHIGH: o.result = {32'd0, a[63:32]};
         K_MUL: o.result = {32'd0, a32} * {32'd0, b32};
         K_MULS: o.result = $unsigned(64'($signed(a32)) * 64'($signed(b32)));
         K_DIV: begin
            if (b32 == 0) o.result = pack_quot_rem('1, a32);
            else o.result = pack_quot_rem(a32 / b32, a32 % b32);
         end
         K_DIVS: begin
            if (b32 == 0) o.result = pack_quot_rem('1, a32);
            else begin
               ma = a32[31] ? -a32 : a32;
               mb = b32[31] ? -b32 : b32;
               q = ma / mb;
               r = ma % mb;
               if (a32[31] != b32[31]) q = -q;
               if (a32[31]) r = -r;
               o.result = pack_quot_rem(q, r);
            end
         end
         K_CMP: begin
            if (cc == CC_NE) o.result = 64'(a32 != b32);
            else if (cc == CC_SLT) o.result = 64'($signed(a32) < $signed(b32));
            else o.bad = 1'b1;
         end
         K_CMP64: begin
            if (cc == CC_NE) o.result = 64'(a != b);
            else if (cc == CC_ULT) o.result = 64'(a < b);
            else if (cc == CC_SLT) o.result = 64'($signed(a) < $signed(b));
            else o.bad = 1'b1;
         end
         K_CONDJMP: begin
            if (cc == CC_EQ) o.taken = (a32 == b32);
            else if (cc == CC_NE) o.taken = (a32 != b32);
            else if (cc == CC_SGT) o.taken = ($signed(a32) > $signed(b32));
            else o.bad = 1'b1;
         end
         K_CONDJMP_P: begin
            if (cc == CC_EQ) o.taken = (a == b);
            else o.bad = 1'b1;
         end
         K_JMP: o.taken = 1'b1;
         default: ;
      endcase
      o.next_index = o.taken ? tgt : cur + 16'd1;
      return o;
   endfunction

   class execute_scoreboard;
      outcome_type pending[$];
      int mismatches = 0;
      int checked = 0;

      function void note_instr(logic [4:0] kind, logic [2:0] cc, logic [63:0] a,
            logic [63:0] b, logic [15:0] cur, logic [15:0] tgt);
         pending.insert(pending.size(), execute_instr(kind, cc, a, b, cur, tgt));
      endfunction

      function void check_result(logic [63:0] res, logic tk, logic [15:0] nxt, logic bad);
         outcome_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result beat: result %h", res);
            return;
         end
         e = pending.pop_front();
         checked++;
         if (res !== e.result || tk !== e.taken || nxt !== e.next_index || bad !== e.bad) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Mismatch: expected %h/%b/%h/%b, got %h/%b/%h/%b",
                  e.result, e.taken, e.next_index, e.bad, res, tk, nxt, bad);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic pop = 1'b0;
   logic full, empty;
   logic [KIND_W-1:0] req_kind = '0;
   logic [COND_W-1:0] req_cond_code = '0;
   logic [WORD_W-1:0] req_src_a = '0, req_src_b = '0;
   logic [INDEX_W-1:0] req_cur_index = '0, req_target_index = '0;
   logic [WORD_W-1:0] rsp_result;
   logic rsp_taken, rsp_bad_condition;
   logic [INDEX_W-1:0] rsp_next_index;

   execute_scoreboard board = new();
   bit quiet_phase = 0;
   int idle_cycles = 0;
   int pop_hold = 0;

   ir_integer_execute_unit_top DUT (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [63:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return 64'd0;
         1: return '1;
         2: return 64'h8000_0000;
         3: return 64'h8000_0000_0000_0000;
         4: return {32'd0, 32'($urandom_range(0, 40))};
         5: return rand64() & 64'hFFFF_FFFF;
         default: return rand64();
      endcase
   endfunction

   // Holds one beat on the request ports until it is taken.
   task automatic send_instr(logic [4:0] kind, logic [2:0] cc, logic [63:0] a,
         logic [63:0] b, logic [15:0] cur, logic [15:0] tgt);
      int gap;
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 14);
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_kind <= kind;
      req_cond_code <= cc;
      req_src_a <= a;
      req_src_b <= b;
      req_cur_index <= cur;
      req_target_index <= tgt;
      @(posedge clock);
      while (full) @(posedge clock);
      board.note_instr(kind, cc, a, b, cur, tgt);
   endtask

   task automatic send_random();
      logic [2:0] cc;
      cc = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      send_instr(($urandom_range(0, 15) == 0) ? 5'($urandom_range(23, 31))
                                              : 5'($urandom_range(0, 22)),
                 cc, pick_operand(), pick_operand(), 16'($urandom()), 16'($urandom()));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
         pop_hold <= 0;
      end else begin
         if (pop && !empty)
            board.check_result(rsp_result, rsp_taken, rsp_next_index, rsp_bad_condition);
         if (quiet_phase) pop <= 1'b1;
         else if (pop_hold > 0) begin
            pop <= 1'b0;
            pop_hold <= pop_hold - 1;
         end else if ($urandom_range(0, 5) == 0) begin
            pop <= 1'b0;
            pop_hold <= $urandom_range(0, 13);
         end else pop <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (!reset && idle_cycles > 5000) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int k = 0; k <= 22; k++)
         send_instr(5'(k), 3'(k % 5), 64'hFFFF_FFFF_8000_0001, 64'h0000_0001_FFFF_FFFF,
                    16'hFFFF, 16'h1234);
      send_instr(K_DIVS, CC_EQ, 64'h8000_0000, 64'hFFFF_FFFF, 16'd0, 16'd0);
      send_instr(K_DIV, CC_EQ, 64'h1234_5678, 64'h1_0000_0000, 16'd7, 16'd0);
      send_instr(K_CMP64, 3'd7, '1, '1, 16'hFFFE, 16'hFFFF);
      send_instr(K_SRA, CC_EQ, 64'h8000_0000, 64'h3F, 16'd1, 16'd2);
      push <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      for (int n = 0; n < 600; n++) begin
         if (n == 450) quiet_phase = 1;
         send_random();
      end
      push <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("Checked %0d result beats: all 23 kinds, bad and unknown codes, edge operands.",
               board.checked);
      if (board.mismatches == 0 && board.pending.size() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule
